@@ rtl/wcc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcc_pkg: shared definitions for the windlass chain counter
// Field widths, item and register codes, controller states, the command and
// status bundles between controller and datapath, and the state decoder.
// ----------------------------------------------------------------------------
package wcc_pkg;

  // Field widths
  localparam int unsigned ACTION_W   = 3;
  localparam int unsigned CODE_W     = 3;
  localparam int unsigned CIRC_W     = 10;
  localparam int unsigned LEN16_W    = 16;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned RODE_W     = 17;
  localparam int unsigned AGE_W      = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Divider: numerator is circumference * 1000, below 2^20
  localparam int unsigned NUM_W      = 20;
  localparam int unsigned DIV_STEPS  = NUM_W;
  localparam int unsigned STEP_W     = 5;
  localparam int unsigned MS_PER_S   = 1000;

  localparam logic [AGE_W-1:0]   AGE_MAX   = '1;
  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

  // Configuration register reset values
  localparam logic [CIRC_W-1:0]  CIRC_RESET    = 10'd30;
  localparam logic [LEN16_W-1:0] TOTAL_RESET   = 16'd5000;
  localparam logic [LEN16_W-1:0] TIMEOUT_RESET = 16'd1000;

  // Item action codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK     = 3'd0,
    ACT_POWER    = 3'd1,
    ACT_DEPLOY   = 3'd2,
    ACT_RETRIEVE = 3'd3,
    ACT_PULSE    = 3'd4
  } action_e;

  // Windlass state codes
  typedef enum logic [CODE_W-1:0] {
    CODE_OFF      = 3'd0,
    CODE_STOPPED  = 3'd1,
    CODE_DEPLOY   = 3'd2,
    CODE_RETRIEVE = 3'd3,
    CODE_FREEFALL = 3'd4
  } code_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CIRC    = 2'd0,
    CFG_TOTAL   = 2'd1,
    CFG_TIMEOUT = 2'd2
  } cfg_idx_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic decode;
    logic div_step;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_room;
  } status_t;

  // Windlass state from speed and line levels
  function automatic code_e code_of(logic moving, logic pwr, logic dep, logic ret);
    code_e c;
    if (moving && !dep && !ret) begin
      c = CODE_FREEFALL;
    end else if (!pwr) begin
      c = CODE_OFF;
    end else if (dep) begin
      c = CODE_DEPLOY;
    end else if (ret) begin
      c = CODE_RETRIEVE;
    end else begin
      c = CODE_STOPPED;
    end
    return c;
  endfunction

endpackage

@@ rtl/wcc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcc_if: channel interfaces of the windlass chain counter
// Input item channel, result channel and configuration write channel, each
// a valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
interface wcc_in_if;
  logic                          valid;
  logic                          ready;
  logic [wcc_pkg::ACTION_W-1:0]  action;
  logic                          level;

  modport source (output valid, action, level, input ready);
  modport sink   (input valid, action, level, output ready);
endinterface

interface wcc_out_if;
  logic                          valid;
  logic                          ready;
  logic [wcc_pkg::CODE_W-1:0]    state_code;
  logic [wcc_pkg::SPEED_W-1:0]   speed_cm_s;
  logic [wcc_pkg::RODE_W-1:0]    rode_cm;
  logic                          state_changed;
  logic                          rode_changed;

  modport source (output valid, state_code, speed_cm_s, rode_cm, state_changed,
                  rode_changed, input ready);
  modport sink   (input valid, state_code, speed_cm_s, rode_cm, state_changed,
                  rode_changed, output ready);
endinterface

interface wcc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wcc_pkg::CFG_IDX_W-1:0]  index;
  logic [wcc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/wcc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcc_ctrl: sequencing controller
// Takes one item, has the datapath decode it, runs the divider when a speed
// must be computed, then hands the result to the output register.
// ----------------------------------------------------------------------------
module wcc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  wcc_pkg::status_t status_i,
  output wcc_pkg::cmd_t    cmd_o
);

  wcc_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wcc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      wcc_pkg::ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
        if (in_valid_i) begin
          state_d = wcc_pkg::ST_DECODE;
        end
      end
      wcc_pkg::ST_DECODE: begin
        cmd_o.decode = 1'b1;
        state_d      = status_i.need_div ? wcc_pkg::ST_DIVIDE : wcc_pkg::ST_FINISH;
      end
      wcc_pkg::ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = wcc_pkg::ST_FINISH;
        end
      end
      wcc_pkg::ST_FINISH: begin
        // wait for the output register to free up
        if (status_i.out_room) begin
          cmd_o.out_load = 1'b1;
          state_d        = wcc_pkg::ST_IDLE;
        end
      end
      default: state_d = wcc_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ rtl/wcc_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcc_dp: datapath of the windlass chain counter
// Configuration registers, line levels, pulse timing, rode length, a
// one-bit-per-cycle restoring divider for speed, and the output register.
// ----------------------------------------------------------------------------
module wcc_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  wcc_pkg::cmd_t                cmd_i,
  output wcc_pkg::status_t             status_o,
  input  logic [wcc_pkg::ACTION_W-1:0] action_i,
  input  logic                         level_i,
  wcc_cfg_if.sink                      cfg_i,
  wcc_out_if.source                    out_o
);

  // Latched item
  logic [wcc_pkg::ACTION_W-1:0] act_q;
  logic                         level_q;

  // Configuration
  logic [wcc_pkg::CIRC_W-1:0]   circ_q;
  logic [wcc_pkg::LEN16_W-1:0]  total_q;
  logic [wcc_pkg::LEN16_W-1:0]  timeout_q;

  // Block state
  logic                         pwr_q, pwr_d;
  logic                         dep_q, dep_d;
  logic                         ret_q, ret_d;
  logic [1:0]                   cnt_q, cnt_d;
  logic [wcc_pkg::AGE_W-1:0]    age_q, age_d;
  logic [wcc_pkg::AGE_W-1:0]    intv_q, intv_d;
  logic [wcc_pkg::SPEED_W-1:0]  speed_q, speed_d;
  logic [wcc_pkg::RODE_W-1:0]   rode_q, rode_d;
  logic                         st_chg_q, st_chg_d;
  logic                         rd_chg_q, rd_chg_d;

  // Divider
  logic [wcc_pkg::AGE_W-1:0]    rem_q, rem_nx;
  logic [wcc_pkg::NUM_W-1:0]    quo_q, quo_nx;
  logic [wcc_pkg::STEP_W-1:0]   step_q;
  logic [wcc_pkg::AGE_W:0]      rem_sh, rem_diff;
  logic                         rem_ge;
  logic [wcc_pkg::NUM_W-1:0]    num;
  logic [wcc_pkg::SPEED_W-1:0]  quo_sat;
  logic                         div_last;

  // Output register
  logic                         out_valid_q;
  logic [wcc_pkg::CODE_W-1:0]   out_code_q;
  logic [wcc_pkg::SPEED_W-1:0]  out_speed_q;
  logic [wcc_pkg::RODE_W-1:0]   out_rode_q;
  logic                         out_st_q, out_rd_q;

  logic [wcc_pkg::AGE_W-1:0]    age_inc;
  logic                         past_timeout;
  logic                         need_div;
  wcc_pkg::code_e               old_code;

  // Item latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      act_q   <= action_i;
      level_q <= level_i;
    end
  end

  // Configuration writes, always accepted
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      circ_q    <= wcc_pkg::CIRC_RESET;
      total_q   <= wcc_pkg::TOTAL_RESET;
      timeout_q <= wcc_pkg::TIMEOUT_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        wcc_pkg::CFG_CIRC:    circ_q    <= cfg_i.data[wcc_pkg::CIRC_W-1:0];
        wcc_pkg::CFG_TOTAL:   total_q   <= cfg_i.data;
        wcc_pkg::CFG_TIMEOUT: timeout_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Tick arithmetic: saturating age and timeout check
  assign age_inc      = (age_q == wcc_pkg::AGE_MAX) ? age_q : age_q + 1'b1;
  assign past_timeout = age_inc > {1'b0, timeout_q};
  assign need_div     = (act_q == wcc_pkg::ACT_TICK) && (cnt_q == 2'd2) &&
                        !past_timeout && (intv_q != '0);
  assign old_code     = wcc_pkg::code_of(speed_q != '0, pwr_q, dep_q, ret_q);

  // Divider step: shift one numerator bit in, subtract when it fits
  assign num      = wcc_pkg::NUM_W'(circ_q) * wcc_pkg::NUM_W'(wcc_pkg::MS_PER_S);
  assign rem_sh   = {rem_q, quo_q[wcc_pkg::NUM_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, intv_q};
  assign rem_diff = rem_sh - {1'b0, intv_q};
  assign rem_nx   = rem_ge ? rem_diff[wcc_pkg::AGE_W-1:0] : rem_sh[wcc_pkg::AGE_W-1:0];
  assign quo_nx   = {quo_q[wcc_pkg::NUM_W-2:0], rem_ge};
  assign quo_sat  = (|quo_nx[wcc_pkg::NUM_W-1:wcc_pkg::SPEED_W]) ? wcc_pkg::SPEED_MAX
                                                                 : quo_nx[wcc_pkg::SPEED_W-1:0];
  assign div_last = step_q == wcc_pkg::STEP_W'(wcc_pkg::DIV_STEPS - 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.decode && need_div) begin
      rem_q  <= '0;
      quo_q  <= num;
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_nx;
      quo_q  <= quo_nx;
      step_q <= step_q + 1'b1;
    end
  end

  // Item decode and state update
  always_comb begin
    pwr_d    = pwr_q;
    dep_d    = dep_q;
    ret_d    = ret_q;
    cnt_d    = cnt_q;
    age_d    = age_q;
    intv_d   = intv_q;
    speed_d  = speed_q;
    rode_d   = rode_q;
    st_chg_d = st_chg_q;
    rd_chg_d = rd_chg_q;
    if (cmd_i.decode) begin
      st_chg_d = 1'b0;
      rd_chg_d = 1'b0;
      unique case (act_q)
        wcc_pkg::ACT_TICK: begin
          age_d = age_inc;
          if (cnt_q != 2'd2) begin
            speed_d = '0;
          end else if (past_timeout) begin
            cnt_d   = '0;
            speed_d = '0;
          end else if (intv_q == '0) begin
            speed_d = wcc_pkg::SPEED_MAX;
          end
          // divided speed is flagged when the divider finishes
          st_chg_d = speed_d != speed_q;
        end
        wcc_pkg::ACT_POWER: begin
          pwr_d    = level_q;
          st_chg_d = wcc_pkg::code_of(speed_q != '0, level_q, dep_q, ret_q) != old_code;
        end
        wcc_pkg::ACT_DEPLOY: begin
          dep_d    = level_q;
          st_chg_d = wcc_pkg::code_of(speed_q != '0, pwr_q, level_q, ret_q) != old_code;
        end
        wcc_pkg::ACT_RETRIEVE: begin
          ret_d    = level_q;
          st_chg_d = wcc_pkg::code_of(speed_q != '0, pwr_q, dep_q, level_q) != old_code;
        end
        wcc_pkg::ACT_PULSE: begin
          intv_d = age_q;
          age_d  = '0;
          if (cnt_q != 2'd2) begin
            cnt_d = cnt_q + 1'b1;
          end
          if (old_code == wcc_pkg::CODE_RETRIEVE) begin
            // hauling in: take one turn off, clamp at zero
            if (rode_q > wcc_pkg::RODE_W'(circ_q)) begin
              rode_d = rode_q - wcc_pkg::RODE_W'(circ_q);
            end else begin
              rode_d = '0;
            end
          end else if (rode_q < wcc_pkg::RODE_W'(total_q)) begin
            rode_d = rode_q + wcc_pkg::RODE_W'(circ_q);
          end
          rd_chg_d = rode_d != rode_q;
        end
        default: ;
      endcase
    end else if (cmd_i.div_step && div_last) begin
      speed_d  = quo_sat;
      st_chg_d = quo_sat != speed_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwr_q    <= 1'b0;
      dep_q    <= 1'b0;
      ret_q    <= 1'b0;
      cnt_q    <= '0;
      age_q    <= '0;
      intv_q   <= '0;
      speed_q  <= '0;
      rode_q   <= '0;
      st_chg_q <= 1'b0;
      rd_chg_q <= 1'b0;
    end else begin
      pwr_q    <= pwr_d;
      dep_q    <= dep_d;
      ret_q    <= ret_d;
      cnt_q    <= cnt_d;
      age_q    <= age_d;
      intv_q   <= intv_d;
      speed_q  <= speed_d;
      rode_q   <= rode_d;
      st_chg_q <= st_chg_d;
      rd_chg_q <= rd_chg_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_code_q  <= old_code;
      out_speed_q <= speed_q;
      out_rode_q  <= rode_q;
      out_st_q    <= st_chg_q;
      out_rd_q    <= rd_chg_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.state_code    = out_code_q;
  assign out_o.speed_cm_s    = out_speed_q;
  assign out_o.rode_cm       = out_rode_q;
  assign out_o.state_changed = out_st_q;
  assign out_o.rode_changed  = out_rd_q;

  assign status_o.need_div = need_div;
  assign status_o.div_last = div_last;
  assign status_o.out_room = !out_valid_q || out_o.ready;

  // Checks
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_o.ready))
    else $error("result loaded over an untaken result");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < intv_q))
    else $error("divider remainder not below divisor");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (intv_q != '0) && $stable(intv_q))
    else $error("divisor zero or changing during divide");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("pulse count out of range");

  a_pulse_age: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.decode && act_q == wcc_pkg::ACT_PULSE) |=> (age_q == '0) && (cnt_q != '0))
    else $error("pulse did not restart age");

endmodule

@@ rtl/windlass_chain_counter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windlass_chain_counter: anchor windlass chain counter
// Tracks line levels, gypsy pulse timing, chain speed and rode deployed.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   carries one item per handshake: action (tick, power, deploy,
//          retrieve line change, or gypsy pulse) and a line level.
//   out_o  returns one result per item: state code, speed in cm/s, rode in
//          cm and two change flags.
//   cfg_i  writes circumference (index 0), total rode (1) and timeout (2);
//          always ready, write only while no item is in flight.
// Timing: one item at a time. An item is decoded in the cycle after it is
//   taken, and its result is then registered in the output register once
//   that has room; only then can a new item be taken. A tick that needs a
//   speed runs the restoring divider between decode and result, one
//   quotient bit per cycle, one for each of the 20 numerator bits.
// Reset: line levels, pulse history, speed and rode clear to zero; the
//   configuration returns to 30 cm, 5000 cm and 1000 ms.
// Stall: a result held in the output register does not block the next item
//   from being taken; that item waits in its final cycle until the held
//   result is taken.
// ----------------------------------------------------------------------------
module windlass_chain_counter (
  input  logic      clk_i,
  input  logic      rst_ni,
  wcc_in_if.sink    in_i,
  wcc_out_if.source out_o,
  wcc_cfg_if.sink   cfg_i
);

  wcc_pkg::cmd_t    cmd;
  wcc_pkg::status_t status;

  // Controller
  wcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath
  wcc_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .action_i (in_i.action),
    .level_i  (in_i.level),
    .cfg_i    (cfg_i),
    .out_o    (out_o)
  );

endmodule

@@ tb/sv/tb_windlass_chain_counter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windlass_chain_counter: self-checking bench for the chain counter
// A queue of pending items feeds a valid/ready driver, and a monitor checks
// every result against a cycle-free model of the windlass held in the
// bench. A directed opening covers every action, the line priorities, zero
// interval and rode clamping. Random phases with both extremes and random
// register settings follow. A last phase without idling drives the speed
// into saturation and then lets the pulse history time out.
// ----------------------------------------------------------------------------
module tb_windlass_chain_counter;
  import wcc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 30;
  localparam int unsigned RANDOM_PHASES  = 5;
  localparam int unsigned PHASE_ITEMS    = 320;
  localparam int unsigned TIMEOUT_TICKS  = 8;

  // Action codes with no meaning, the block must leave them alone
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = ACTION_W'(ACT_PULSE + 1);
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = '1;
  localparam logic [1:0]          PULSE_HISTORY = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                level;
  } windlass_item_t;

  typedef struct packed {
    code_e              code;
    logic [SPEED_W-1:0] speed;
    logic [RODE_W-1:0]  rode;
    logic               state_chg;
    logic               rode_chg;
  } windlass_report_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  wcc_in_if  in_if ();
  wcc_out_if out_if ();
  wcc_cfg_if cfg_if ();

  windlass_chain_counter u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Model configuration and state of the windlass
  logic [CIRC_W-1:0]  circ_cm       = CIRC_RESET;
  logic [LEN16_W-1:0] rode_limit_cm = TOTAL_RESET;
  logic [LEN16_W-1:0] stale_ms      = TIMEOUT_RESET;
  logic               mains_on       = 1'b0;
  logic               deploy_on      = 1'b0;
  logic               retrieve_on    = 1'b0;
  logic [1:0]         pulses_seen    = '0;
  logic [AGE_W-1:0]   ms_since_pulse = '0;
  logic [AGE_W-1:0]   pulse_gap_ms   = '0;
  logic [SPEED_W-1:0] speed_now      = '0;
  logic [RODE_W-1:0]  rode_now       = '0;

  windlass_item_t   pending_items[$];
  windlass_report_t awaited_reports[$];

  logic        in_taken       = 1'b0;
  logic        idling_on      = 1'b1;
  int unsigned gap_left       = 0;
  int unsigned stall_left     = 0;
  int unsigned idle_cycles    = 0;
  int unsigned mismatch_count = 0;
  int unsigned stim_count     = 0;

  // Freefall wins over everything, then power, deploy, retrieve
  function automatic code_e windlass_code();
    code_e c;
    if (speed_now != '0 && !deploy_on && !retrieve_on) begin
      c = CODE_FREEFALL;
    end else if (!mains_on) begin
      c = CODE_OFF;
    end else if (deploy_on) begin
      c = CODE_DEPLOY;
    end else if (retrieve_on) begin
      c = CODE_RETRIEVE;
    end else begin
      c = CODE_STOPPED;
    end
    return c;
  endfunction

  // Apply one item to the model and return the report it produces
  function automatic windlass_report_t advance_windlass(input windlass_item_t it);
    code_e              code_was;
    logic [SPEED_W-1:0] speed_was;
    logic [RODE_W-1:0]  rode_was;
    logic [31:0]        quot;
    windlass_report_t   rep;
    code_was      = windlass_code();
    speed_was     = speed_now;
    rode_was      = rode_now;
    rep.state_chg = 1'b0;
    rep.rode_chg  = 1'b0;
    case (it.action)
      ACT_TICK: begin
        if (ms_since_pulse != AGE_MAX) ms_since_pulse++;
        if (pulses_seen < PULSE_HISTORY) begin
          speed_now = '0;
        end else if (ms_since_pulse > {1'b0, stale_ms}) begin
          pulses_seen = '0;
          speed_now   = '0;
        end else if (pulse_gap_ms == '0) begin
          speed_now = SPEED_MAX;
        end else begin
          quot      = (32'(circ_cm) * 32'(MS_PER_S)) / 32'(pulse_gap_ms);
          speed_now = (quot > 32'(SPEED_MAX)) ? SPEED_MAX : quot[SPEED_W-1:0];
        end
        rep.state_chg = speed_now != speed_was;
      end
      ACT_POWER, ACT_DEPLOY, ACT_RETRIEVE: begin
        if (it.action == ACT_POWER) begin
          mains_on = it.level;
        end else if (it.action == ACT_DEPLOY) begin
          deploy_on = it.level;
        end else begin
          retrieve_on = it.level;
        end
        rep.state_chg = windlass_code() != code_was;
      end
      ACT_PULSE: begin
        pulse_gap_ms   = ms_since_pulse;
        ms_since_pulse = '0;
        if (pulses_seen < PULSE_HISTORY) pulses_seen++;
        // Retrieving pays chain in (clamped at zero), anything else pays out
        if (code_was == CODE_RETRIEVE) begin
          if (rode_now > RODE_W'(circ_cm)) begin
            rode_now -= RODE_W'(circ_cm);
          end else begin
            rode_now = '0;
          end
        end else if (rode_now < RODE_W'(rode_limit_cm)) begin
          rode_now += RODE_W'(circ_cm);
        end
        rep.rode_chg = rode_now != rode_was;
      end
      default: begin
      end
    endcase
    rep.code  = windlass_code();
    rep.speed = speed_now;
    rep.rode  = rode_now;
    return rep;
  endfunction

  task automatic flag_diff(input string what, input logic [31:0] want,
                           input logic [31:0] got);
    mismatch_count++;
    $display("%0t ns: %s expected %0d, actual %0d", $time, what, want, got);
  endtask

  task automatic push_item(input logic [ACTION_W-1:0] act, input logic lvl);
    pending_items.push_back('{action: act, level: lvl});
    if (act <= ACT_PULSE) stim_count++;
  endtask

  // Wait until the block has drained and nothing is left in flight
  task automatic wait_quiet();
    while (pending_items.size() != 0 || in_if.valid || awaited_reports.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_CIRC:    circ_cm       = value[CIRC_W-1:0];
      CFG_TOTAL:   rode_limit_cm = value;
      CFG_TIMEOUT: stale_ms      = value;
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Input acceptance: predict at the edge the item is taken
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_if.valid && in_if.ready;
    if (in_taken) begin
      awaited_reports.push_back(advance_windlass('{action: in_if.action,
                                                   level: in_if.level}));
    end
  end

  // Item driver with random idle bursts after accepted items
  always @(negedge clk_i) begin
    windlass_item_t nxt;
    if (rst_ni && (!in_if.valid || in_taken)) begin
      if (gap_left != 0) begin
        in_if.valid <= 1'b0;
        gap_left--;
      end else if (pending_items.size() != 0) begin
        nxt = pending_items.pop_front();
        in_if.action <= nxt.action;
        in_if.level  <= nxt.level;
        in_if.valid  <= 1'b1;
        if (idling_on && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 15);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result backpressure in bursts
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      out_if.ready <= 1'b0;
      stall_left = $urandom_range(1, 15) - 1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    windlass_report_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (awaited_reports.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: no result expected, actual code %0d speed %0d rode %0d",
                 $time, out_if.state_code, out_if.speed_cm_s, out_if.rode_cm);
      end else begin
        want = awaited_reports.pop_front();
        if (out_if.state_code !== want.code)
          flag_diff("state_code", want.code, out_if.state_code);
        if (out_if.speed_cm_s !== want.speed)
          flag_diff("speed_cm_s", want.speed, out_if.speed_cm_s);
        if (out_if.rode_cm !== want.rode)
          flag_diff("rode_cm", want.rode, out_if.rode_cm);
        if (out_if.state_changed !== want.state_chg)
          flag_diff("state_changed", want.state_chg, out_if.state_changed);
        if (out_if.rode_changed !== want.rode_chg)
          flag_diff("rode_changed", want.rode_chg, out_if.rode_changed);
      end
    end
  end

  // Watchdog on cycles with no handshake anywhere
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int unsigned r;
    int unsigned n;
    int unsigned g;
    int unsigned gap_cap;
    logic [CFG_DATA_W-1:0] circ_val;
    logic [CFG_DATA_W-1:0] total_val;
    logic [CFG_DATA_W-1:0] stale_val;

    in_if.valid   = 1'b0;
    in_if.action  = ACT_TICK;
    in_if.level   = 1'b0;
    out_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = CFG_CIRC;
    cfg_if.data   = '0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed opening at reset configuration
    push_item(ACT_SPARE_LO, 1'b1);
    push_item(ACT_SPARE_HI, 1'b0);
    push_item(ACTION_W'(ACT_SPARE_LO + 1), 1'b1);
    push_item(ACT_TICK, 1'b1);           // no pulses yet, speed stays zero
    push_item(ACT_POWER, 1'b1);
    push_item(ACT_DEPLOY, 1'b1);
    push_item(ACT_PULSE, 1'b0);
    push_item(ACT_PULSE, 1'b1);          // back to back: zero interval
    push_item(ACT_TICK, 1'b0);           // speed saturates
    push_item(ACT_DEPLOY, 1'b0);         // moving with both lines low: freefall
    push_item(ACT_PULSE, 1'b0);
    push_item(ACT_TICK, 1'b0);
    push_item(ACT_TICK, 1'b1);
    push_item(ACT_RETRIEVE, 1'b1);
    push_item(ACT_PULSE, 1'b0);
    push_item(ACT_PULSE, 1'b0);
    push_item(ACT_PULSE, 1'b1);          // rode equal to one turn clamps to zero
    push_item(ACT_PULSE, 1'b0);          // retrieving at zero rode: no change
    push_item(ACT_POWER, 1'b0);
    push_item(ACT_RETRIEVE, 1'b0);
    push_item(ACT_TICK, 1'b0);

    // Random phases, one register setting each
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_quiet();
      case (ph)
        0: begin
          circ_val  = 16'd1;
          total_val = 16'd0;
          stale_val = 16'd1;
        end
        1: begin
          circ_val  = 16'd1023;
          total_val = '1;
          stale_val = '1;
        end
        2: begin
          circ_val  = CFG_DATA_W'($urandom_range(1, 1023));
          total_val = CFG_DATA_W'($urandom_range(0, 3000));
          stale_val = CFG_DATA_W'($urandom_range(1, 40));
        end
        default: begin
          circ_val  = CFG_DATA_W'($urandom_range(1, 1023));
          total_val = CFG_DATA_W'($urandom);
          stale_val = CFG_DATA_W'($urandom_range(1, 40));
        end
      endcase
      write_reg(CFG_CIRC, circ_val);
      write_reg(CFG_TOTAL, total_val);
      write_reg(CFG_TIMEOUT, stale_val);
      gap_cap = (stale_val < 30) ? stale_val + 2 : 30;

      stim_count = 0;
      while (stim_count < PHASE_ITEMS) begin
        r = $urandom_range(0, 9);
        if (r <= 5) begin
          // pulse train with tick gaps around the timeout
          n = $urandom_range(1, 6);
          repeat (n) begin
            push_item(ACT_PULSE, 1'($urandom));
            g = $urandom_range(0, gap_cap);
            repeat (g) push_item(ACT_TICK, 1'($urandom));
          end
        end else if (r <= 7) begin
          push_item(ACTION_W'($urandom_range(ACT_POWER, ACT_RETRIEVE)), 1'($urandom));
          if ($urandom_range(0, 1) == 0) push_item(ACT_TICK, 1'($urandom));
        end else if (r == 8) begin
          // noise, spare codes included
          n = $urandom_range(1, 4);
          repeat (n) push_item(ACTION_W'($urandom_range(ACT_TICK, ACT_SPARE_HI)),
                               1'($urandom));
        end else begin
          n = $urandom_range(1, 60);
          repeat (n) push_item(ACT_TICK, 1'($urandom));
        end
      end
    end

    // Last part without idling: speed saturation at one ms interval, then
    // the pulse history times out
    wait_quiet();
    idling_on = 1'b0;
    write_reg(CFG_CIRC, 16'd1023);
    write_reg(CFG_TIMEOUT, 16'd2);
    push_item(ACT_PULSE, 1'b0);
    push_item(ACT_TICK, 1'b0);
    push_item(ACT_PULSE, 1'b0);
    push_item(ACT_TICK, 1'b0);
    push_item(ACT_TICK, 1'b1);
    push_item(ACT_PULSE, 1'b1);
    repeat (TIMEOUT_TICKS) push_item(ACT_TICK, 1'b0);
    push_item(ACT_PULSE, 1'b0);
    push_item(ACT_TICK, 1'b0);

    wait_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/wcc_pkg.sv
rtl/wcc_if.sv
rtl/wcc_ctrl.sv
rtl/wcc_dp.sv
rtl/windlass_chain_counter.sv
tb/sv/tb_windlass_chain_counter.sv
